### design/dvrl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dvrl_pkg
// Shared widths, register indexes and the per-item status struct of the
// deja vu random loop.
// ----------------------------------------------------------------------------
package dvrl_pkg;

  localparam int LOOP_DEPTH_DEF = 16;

  localparam int WORD_W     = 32;
  localparam int SAMPLE_W   = 16;
  localparam int POS_W      = 4;
  localparam int AMT_W      = 17;
  localparam int LEN_W      = 5;
  localparam int PROB_W     = 33;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam int LEN_MAX   = 16;
  localparam int LEN_RESET = 8;

  localparam logic [AMT_W-1:0] AMT_ONE  = 17'd65536;
  localparam logic [AMT_W-1:0] AMT_HALF = 17'd32768;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_AMOUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 2'd1;

  // Status of one item as it leaves the decision logic.
  typedef struct packed {
    logic              mutated;
    logic              wr_en;
    logic [POS_W-1:0]  position;
  } step_info_t;

endpackage
`default_nettype wire

### design/deja_vu_random_loop.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// deja_vu_random_loop
// Looping random sequence: each item of three random words yields one value
// replayed from, or freshly written into, a circular loop store.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid_i/in_ready_o    gate_word, fresh_word, jump_word
//   out      output     out_valid_o/out_ready_i  sample_value, position, mutated
//   cfg      input      cfg_valid_i/cfg_ready_o  cfg_index (0 amount, 1 length), cfg_data
//
// One item per cycle sustained while the result is not stalled. An item is
// held in the input register, then passes the decision logic and the store's
// registered read port into the result register, from which it is valid.
// Reset empties both registers and makes the store read as zero at once.
// A stalled result holds its register; the input register still takes one item.
// A register write waits while an item sits in the input register.
// ----------------------------------------------------------------------------
module deja_vu_random_loop #(
  parameter int LOOP_DEPTH = dvrl_pkg::LOOP_DEPTH_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [dvrl_pkg::WORD_W-1:0]     gate_word_i,
  input  wire logic [dvrl_pkg::WORD_W-1:0]     fresh_word_i,
  input  wire logic [dvrl_pkg::WORD_W-1:0]     jump_word_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic      [dvrl_pkg::SAMPLE_W-1:0]   sample_value_o,
  output logic      [dvrl_pkg::POS_W-1:0]      position_o,
  output logic                                 mutated_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [dvrl_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [dvrl_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int AW = $clog2(LOOP_DEPTH);

  logic                          in_vld_q;
  logic [dvrl_pkg::WORD_W-1:0]   gate_q, fresh_q, jump_q;
  logic                          out_vld_q;
  logic [dvrl_pkg::POS_W-1:0]    pos_q;
  logic                          mut_q;
  logic                          advance;
  logic                          fire;
  dvrl_pkg::step_info_t          info;
  logic [AW-1:0]                 wr_addr;
  logic [AW-1:0]                 rd_addr;

  assign advance     = !out_vld_q || out_ready_i;
  assign fire        = in_vld_q && advance;
  assign in_ready_o  = !in_vld_q || advance;
  // A write never meets an item that updates the step in the same cycle.
  assign cfg_ready_o = !in_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      gate_q  <= gate_word_i;
      fresh_q <= fresh_word_i;
      jump_q  <= jump_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      pos_q <= info.position;
      mut_q <= info.mutated;
    end
  end

  dvrl_state #(
    .DEPTH (LOOP_DEPTH),
    .AW    (AW)
  ) u_state (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .fire_i      (fire),
    .gate_word_i (gate_q),
    .jump_word_i (jump_q),
    .info_o      (info),
    .wr_addr_o   (wr_addr),
    .rd_addr_o   (rd_addr)
  );

  dvrl_store #(
    .DEPTH (LOOP_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (fire && info.wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (fresh_q[dvrl_pkg::WORD_W-1 -: dvrl_pkg::SAMPLE_W]),
    .rd_en_i   (fire),
    .rd_addr_i (rd_addr),
    .rd_data_o (sample_value_o)
  );

  assign out_valid_o = out_vld_q;
  assign position_o  = pos_q;
  assign mutated_o   = mut_q;

endmodule
`default_nettype wire

### design/dvrl_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dvrl_store
// Circular loop store: one write port, one registered read port with
// write-first forwarding, and per-entry valid bits so that reset reads zero.
// ----------------------------------------------------------------------------
module dvrl_store #(
  parameter int DEPTH = dvrl_pkg::LOOP_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          wr_en_i,
  input  wire logic [AW-1:0]                 wr_addr_i,
  input  wire logic [dvrl_pkg::SAMPLE_W-1:0] wr_data_i,
  input  wire logic                          rd_en_i,
  input  wire logic [AW-1:0]                 rd_addr_i,
  output logic      [dvrl_pkg::SAMPLE_W-1:0] rd_data_o
);

  logic [dvrl_pkg::SAMPLE_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]              vld_q;
  logic [dvrl_pkg::SAMPLE_W-1:0] rd_q;
  logic                          rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en_i) begin
      vld_q[wr_addr_i] <= 1'b1;
    end
  end

  // A read of the entry written in the same cycle returns the new value.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_q <= wr_data_i;
      end else begin
        rd_q <= mem[rd_addr_i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else if (rd_en_i) begin
      rd_vld_q <= vld_q[rd_addr_i] || (wr_en_i && (wr_addr_i == rd_addr_i));
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule
`default_nettype wire

### design/dvrl_state.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dvrl_state
// Configuration registers, write head and step index. Decides per item
// whether it mutates, updates the loop state and computes the read slot.
// ----------------------------------------------------------------------------
module dvrl_state #(
  parameter int DEPTH = dvrl_pkg::LOOP_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [dvrl_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [dvrl_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                            fire_i,
  input  wire logic [dvrl_pkg::WORD_W-1:0]     gate_word_i,
  input  wire logic [dvrl_pkg::WORD_W-1:0]     jump_word_i,
  output dvrl_pkg::step_info_t                 info_o,
  output logic      [AW-1:0]                   wr_addr_o,
  output logic      [AW-1:0]                   rd_addr_o
);

  localparam int LEN_W  = dvrl_pkg::LEN_W;
  localparam int POS_W  = dvrl_pkg::POS_W;
  localparam int SW     = $clog2(2 * DEPTH + dvrl_pkg::LEN_MAX) + 1;
  localparam int LEN_RST = (DEPTH < dvrl_pkg::LEN_RESET) ? DEPTH : dvrl_pkg::LEN_RESET;

  logic [dvrl_pkg::PROB_W-1:0] prob_q, prob_d;
  logic                        low_q, low_d;
  logic [LEN_W-1:0]            len_q;
  logic [AW-1:0]               head_q, head_d;
  logic [POS_W-1:0]            step_q, step_d;

  logic [dvrl_pkg::AMT_W-1:0]  amt_clamp;
  logic [dvrl_pkg::AMT_W:0]    amt_twice;
  logic [dvrl_pkg::AMT_W-1:0]  dist_mag;
  logic [2*dvrl_pkg::AMT_W-1:0] dist_sq;
  logic [LEN_W-1:0]            len_new;
  logic                        len_ok;
  logic                        mutate;
  logic [dvrl_pkg::WORD_W+LEN_W-1:0] jump_prod;
  logic [LEN_W-1:0]            step_inc;
  logic [SW-1:0]               slot_sum;

  // Remainder of a step index by a loop length, by restoring division.
  function automatic logic [POS_W-1:0] len_mod(input logic [POS_W-1:0] s,
                                               input logic [LEN_W-1:0] l);
    logic [LEN_W-1:0] r;
    r = '0;
    for (int i = POS_W - 1; i >= 0; i--) begin
      r = {r[LEN_W-2:0], s[i]};
      if (r >= l) begin
        r = r - l;
      end
    end
    return r[POS_W-1:0];
  endfunction

  // Mutation probability |2a - 1|^2 as a Q1.32 value, held with the amount.
  always_comb begin
    amt_clamp = (cfg_data_i[dvrl_pkg::AMT_W-1:0] > dvrl_pkg::AMT_ONE) ?
                dvrl_pkg::AMT_ONE : cfg_data_i[dvrl_pkg::AMT_W-1:0];
    amt_twice = {amt_clamp, 1'b0};
    if (amt_twice >= {1'b0, dvrl_pkg::AMT_ONE}) begin
      dist_mag = dvrl_pkg::AMT_W'(amt_twice - {1'b0, dvrl_pkg::AMT_ONE});
    end else begin
      dist_mag = dvrl_pkg::AMT_W'({1'b0, dvrl_pkg::AMT_ONE} - amt_twice);
    end
    dist_sq = dist_mag * dist_mag;
    prob_d  = dist_sq[dvrl_pkg::PROB_W-1:0];
    low_d   = (amt_clamp <= dvrl_pkg::AMT_HALF);
  end

  assign len_new = cfg_data_i[LEN_W-1:0];
  assign len_ok  = (len_new != '0) && (int'(len_new) <= dvrl_pkg::LEN_MAX) &&
                   (int'(len_new) <= DEPTH);

  assign mutate    = ({1'b0, gate_word_i} < prob_q);
  assign jump_prod = jump_word_i * len_q;
  assign step_inc  = {1'b0, step_q} + 1'b1;

  always_comb begin
    head_d = head_q;
    if (mutate && low_q) begin
      head_d = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
      step_d = POS_W'(len_q - 1'b1);
    end else if (mutate) begin
      step_d = jump_prod[dvrl_pkg::WORD_W +: POS_W];
    end else begin
      step_d = (step_inc >= len_q) ? '0 : step_inc[POS_W-1:0];
    end
  end

  // Slot = (head + DEPTH - length + step) mod DEPTH; the sum stays below 2*DEPTH.
  always_comb begin
    slot_sum = SW'(head_d) + SW'(DEPTH) + SW'(step_d) - SW'(len_q);
    if (slot_sum >= SW'(DEPTH)) begin
      slot_sum = slot_sum - SW'(DEPTH);
    end
  end

  assign rd_addr_o        = slot_sum[AW-1:0];
  assign wr_addr_o        = head_q;
  assign info_o.mutated   = mutate;
  assign info_o.wr_en     = mutate && low_q;
  assign info_o.position  = step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prob_q <= {1'b1, {(dvrl_pkg::PROB_W-1){1'b0}}};
      low_q  <= 1'b1;
      len_q  <= LEN_W'(LEN_RST);
      head_q <= '0;
      step_q <= '0;
    end else if (fire_i) begin
      head_q <= head_d;
      step_q <= step_d;
    end else if (cfg_we_i) begin
      if (cfg_index_i == dvrl_pkg::REG_AMOUNT) begin
        prob_q <= prob_d;
        low_q  <= low_d;
      end else if ((cfg_index_i == dvrl_pkg::REG_LENGTH) && len_ok) begin
        len_q  <= len_new;
        step_q <= len_mod(step_q, len_new);
      end
    end
  end

endmodule
`default_nettype wire
